// File: hw/rtl/json_string_unescape_utf8_unit_macros.svh
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

// Checks that hold at every clock edge outside reset.
`define JSU_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("jsu: check failed");

// Checks that relate one cycle to the next.
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsu: check failed");

`endif

// File: hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps
package jsu_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U      = 8'h75;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_UNI  = 2'd2
  } mode_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [1:0]      num;
    logic [2:0][7:0] bytes;
    logic            has;
    logic            err;
    logic            last;
  } bundle_t;

  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      default: r = c;
    endcase
    return r;
  endfunction

  // Returns {valid, nibble}.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

// File: hw/rtl/jsu_if.sv
`timescale 1ns / 1ps
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       out_last;
  logic       hex_error;
  modport source (output valid, output out_byte, output has_byte, output out_last,
                  output hex_error, input ready);
  modport sink (input valid, input out_byte, input has_byte, input out_last,
                input hex_error, output ready);
endinterface

// File: hw/rtl/jsu_front.sv
`timescale 1ns / 1ps
module jsu_front (
  input  logic             clk,
  input  logic             rst,
  jsu_in_if.sink           in_chan,
  input  logic             q_full,
  output logic             push,
  output jsu_pkg::bundle_t bundle
);
  import jsu_pkg::*;

  mode_t      mode, mode_next;
  logic [1:0] hex_count, hex_count_next;
  logic [7:0] held [3];
  logic [7:0] held_next [3];

  logic       accept;
  logic [7:0] b;
  logic       last;

  logic [7:0]      uc [4];
  logic [4:0]      hn [4];
  logic            uni_ok;
  logic [15:0]     uni_val;
  logic [1:0]      uni_num;
  logic [2:0][7:0] uni_bytes;

  logic [7:0]      tb [4];
  logic [2:0]      tail_len;
  logic            tail_skip;
  logic [1:0]      tail_num;
  logic [2:0][7:0] tail_bytes;

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && in_chan.ready;
  assign b = in_chan.in_byte;
  assign last = in_chan.in_last;

  always_comb begin
    mode_next = mode;
    hex_count_next = hex_count;
    held_next = held;
    case (mode)
      MODE_ESC: begin
        mode_next = MODE_TEXT;
        if (b == CHAR_U && !last) begin
          mode_next = MODE_UNI;
          hex_count_next = 2'd0;
          held_next = '{default: 8'h00};
        end
      end
      MODE_UNI: begin
        if (hex_count == 2'd3) begin
          mode_next = MODE_TEXT;
          hex_count_next = 2'd0;
          held_next = '{default: 8'h00};
        end else if (last) begin
          mode_next = MODE_TEXT;
        end else begin
          held_next[hex_count] = b;
          hex_count_next = hex_count + 2'd1;
        end
      end
      default: begin
        mode_next = (b == CHAR_BSLASH && !last) ? MODE_ESC : MODE_TEXT;
      end
    endcase
    if (last) begin
      mode_next = MODE_TEXT;
      hex_count_next = 2'd0;
      held_next = '{default: 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TEXT;
      hex_count <= 2'd0;
      held <= '{default: 8'h00};
    end else if (accept) begin
      mode <= mode_next;
      hex_count <= hex_count_next;
      held <= held_next;
    end
  end

  // Value of the leading hex digits of the four characters after the u.
  always_comb begin
    uc[0] = held[0];
    uc[1] = held[1];
    uc[2] = held[2];
    uc[3] = b;
    uni_ok = 1'b1;
    uni_val = 16'd0;
    for (int j = 0; j < 4; j++) begin
      hn[j] = hex_nibble(uc[j]);
      if (uni_ok && hn[j][4]) uni_val = {uni_val[11:0], hn[j][3:0]};
      else uni_ok = 1'b0;
    end
    uni_bytes = '0;
    if (uni_val < 16'h0080) begin
      uni_num = 2'd1;
      uni_bytes[0] = uni_val[7:0];
    end else if (uni_val < 16'h0800) begin
      uni_num = 2'd2;
      uni_bytes[0] = 8'hC0 | {3'b000, uni_val[10:6]};
      uni_bytes[1] = 8'h80 | {2'b00, uni_val[5:0]};
    end else begin
      uni_num = 2'd3;
      uni_bytes[0] = 8'hE0 | {4'h0, uni_val[15:12]};
      uni_bytes[1] = 8'h80 | {2'b00, uni_val[11:6]};
      uni_bytes[2] = 8'h80 | {2'b00, uni_val[5:0]};
    end
  end

  // A string that ends inside a unicode escape: the held characters are
  // decoded again as ordinary text.
  always_comb begin
    tb[0] = held[0];
    tb[1] = held[1];
    tb[2] = held[2];
    tb[3] = 8'h00;
    tb[hex_count] = b;
    tail_len = {1'b0, hex_count} + 3'd1;
    tail_skip = 1'b0;
    tail_num = 2'd0;
    tail_bytes = '0;
    for (int i = 0; i < 3; i++) begin
      if (3'(i) < tail_len) begin
        if (tail_skip) begin
          tail_skip = 1'b0;
        end else if (tb[i] == CHAR_BSLASH && 3'(i + 1) < tail_len) begin
          tail_skip = 1'b1;
          if (tb[i + 1] != CHAR_U) begin
            tail_bytes[tail_num] = map_escape(tb[i + 1]);
            tail_num = tail_num + 2'd1;
          end
        end else begin
          tail_bytes[tail_num] = tb[i];
          tail_num = tail_num + 2'd1;
        end
      end
    end
  end

  always_comb begin
    bundle.num = 2'd0;
    bundle.bytes = '0;
    bundle.has = 1'b1;
    bundle.err = 1'b0;
    bundle.last = last;
    case (mode)
      MODE_ESC: begin
        if (b != CHAR_U) begin
          bundle.num = 2'd1;
          bundle.bytes[0] = map_escape(b);
        end
      end
      MODE_UNI: begin
        if (hex_count == 2'd3) begin
          if (!hn[0][4]) begin
            bundle.num = 2'd1;
            bundle.has = 1'b0;
            bundle.err = 1'b1;
          end else begin
            bundle.num = uni_num;
            bundle.bytes = uni_bytes;
          end
        end else if (last) begin
          bundle.num = tail_num;
          bundle.bytes = tail_bytes;
        end
      end
      default: begin
        if (!(b == CHAR_BSLASH && !last)) begin
          bundle.num = 2'd1;
          bundle.bytes[0] = b;
        end
      end
    endcase
    // A string end with nothing to show still gets an end marker.
    if (last && bundle.num == 2'd0) begin
      bundle.num = 2'd1;
      bundle.has = 1'b0;
    end
    push = accept && (bundle.num != 2'd0);
  end

endmodule

// File: hw/rtl/jsu_queue.sv
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_unit_macros.svh"
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jsu_pkg::bundle_t wr_data,
  output logic             full,
  input  logic             pop,
  output jsu_pkg::bundle_t head,
  output logic             head_valid
);
  import jsu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  `JSU_ASSERT_ALWAYS(a_no_overflow, !(push && full))
  `JSU_ASSERT_ALWAYS(a_no_underflow, !(pop && !head_valid))
  `JSU_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + CNT_W'(1))

endmodule

// File: hw/rtl/jsu_back.sv
`timescale 1ns / 1ps
module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  jsu_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             pop,
  jsu_out_if.source        out_chan
);
  import jsu_pkg::*;

  logic [1:0] idx;
  logic       ov;
  logic [7:0] obyte;
  logic       ohas, olast, oerr;
  logic       final_item;
  logic       load;

  assign final_item = (idx == head.num - 2'd1);
  assign load = head_valid && (!ov || out_chan.ready);
  assign pop = load && final_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      idx <= 2'd0;
    end else begin
      if (load) ov <= 1'b1;
      else if (out_chan.ready) ov <= 1'b0;
      if (load) idx <= final_item ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte <= head.has ? head.bytes[idx] : 8'h00;
      ohas <= head.has;
      oerr <= head.err;
      olast <= head.last && final_item;
    end
  end

  assign out_chan.valid = ov;
  assign out_chan.out_byte = obyte;
  assign out_chan.has_byte = ohas;
  assign out_chan.out_last = olast;
  assign out_chan.hex_error = oerr;

endmodule

// File: hw/rtl/json_string_unescape_utf8_unit.sv
`timescale 1ns / 1ps
// JSON string-body unescaper with UTF-8 output. One byte of the escaped
// string is accepted per cycle; the front decoder turns each byte into zero
// to three result bytes and places them as one entry in a queue of DEPTH
// entries, and the back end sends them from an output register at one
// result per cycle while out_chan is ready. A unicode escape of six input
// bytes gives at most three results, so both sides run at one transfer per
// cycle; input is held off only while the queue is full, which happens
// when the output side stalls. Results pass through the queue memory and
// the output register. No clearing pass is needed after reset.
module json_string_unescape_utf8_unit #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  jsu_in_if.sink    in_chan,
  jsu_out_if.source out_chan
);
  import jsu_pkg::*;

  bundle_t bundle, head;
  logic    push, pop, full, head_valid;

  jsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_chan (in_chan),
    .q_full  (full),
    .push    (push),
    .bundle  (bundle)
  );

  jsu_queue #(.DEPTH(DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_data    (bundle),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule
